### rtl/ipd_pkg.sv
// Shared types and constants for the pulse-distance IR decoder.
// Has no dependencies. The window unit, the top level and the checker import it.
package ipd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_RUN      = 3'd1,
		ST_TIMEOUT  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_STOP     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_HDR_SPACE = 3'd0,
		PH_HDR_MARK  = 3'd1,
		PH_BIT_SPACE = 3'd2,
		PH_BIT_MARK  = 3'd3,
		PH_AFTER_GAP = 3'd4,
		PH_ERROR     = 3'd5
	} phase_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TOLERANCE    = 3'd0;
	localparam logic [2:0] CFG_HEADER_SPACE = 3'd1;
	localparam logic [2:0] CFG_HEADER_MARK  = 3'd2;
	localparam logic [2:0] CFG_BIT_SPACE    = 3'd3;
	localparam logic [2:0] CFG_ZERO_MARK    = 3'd4;
	localparam logic [2:0] CFG_ONE_MARK     = 3'd5;
	localparam logic [2:0] CFG_GAP          = 3'd6;
	localparam logic [2:0] CFG_END_TIMEOUT  = 3'd7;

	// Register values after reset.
	localparam logic [15:0] RST_TOLERANCE    = 16'd200;
	localparam logic [15:0] RST_HEADER_SPACE = 16'd3500;
	localparam logic [15:0] RST_HEADER_MARK  = 16'd1760;
	localparam logic [15:0] RST_BIT_SPACE    = 16'd435;
	localparam logic [15:0] RST_ZERO_MARK    = 16'd435;
	localparam logic [15:0] RST_ONE_MARK     = 16'd1295;
	localparam logic [15:0] RST_GAP          = 16'd30000;
	localparam logic [31:0] RST_END_TIMEOUT  = 32'd31000;

	localparam int unsigned GAP_COUNT_MAX = 3;

endpackage

### rtl/ipd_window.sv
// Tolerance window check of one measured interval against one nominal interval.
// Depends on ipd_pkg only by convention; purely combinational.
module ipd_window
	import ipd_pkg::*;
(
	input  logic [15:0] nominal,
	input  logic [15:0] tolerance,
	input  logic [31:0] elapsed,
	output logic        hit
);

	logic [15:0] lo;
	logic [16:0] hi;

	// The lower bound stops at zero; the upper bound keeps its carry.
	always_comb begin
		lo  = (nominal > tolerance) ? (nominal - tolerance) : 16'd0;
		hi  = {1'b0, nominal} + {1'b0, tolerance};
		hit = (elapsed >= {16'd0, lo}) && (elapsed <= {15'd0, hi});
	end

endmodule

### rtl/ir_pulse_distance_decoder.sv
// Pulse-distance IR remote decoder: input register, decode logic and result register.
// Depends on ipd_pkg and ipd_window.
//
// Usage: each input word carries one sampled receiver level with its microsecond
// timestamp, or a rearm command (operation = 1). Each accepted word yields exactly
// one result word: the run status, an optional decoded bit with its frame position,
// the running bit count and the frame-ready and error flags.
// Both channels use valid and stall; a word moves on a rising edge with valid high
// and stall low. The user must write the configuration registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// An accepted word passes from the input register through the decode logic into the
// result register. A word can be accepted every cycle while the output is not stalled;
// the throughput is then one word per cycle, the decoder state updating with each word.
// When the receiver stalls, the result register holds its word; the input register
// then fills and in_stall rises in the same cycle that out_stall holds the output.
// Reset clears both registers, returns every configuration register to its default
// and leaves the decoder idle, waiting for a low level to arm it.
module ir_pulse_distance_decoder
	import ipd_pkg::*;
#(
	parameter int unsigned FRAME_BITS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic        line_level,
	input  logic [31:0] now_us,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        bit_valid,
	output logic        bit_value,
	output logic [6:0]  bit_index,
	output logic [7:0]  bit_count,
	output logic        frame_ready,
	output logic        decode_error
);

	localparam logic [7:0] FRAME_LIMIT = 8'(FRAME_BITS);

	// configuration registers
	logic [15:0] tolerance_q, header_space_q, header_mark_q, bit_space_q;
	logic [15:0] zero_mark_q, one_mark_q, gap_q;
	logic [31:0] end_timeout_q;

	// input register
	logic        valid_s1;
	logic        operation_s1;
	logic        level_s1;
	logic [31:0] now_s1;

	// decoder state
	status_t     status_q, status_n;
	phase_t      phase_q, phase_n;
	logic        prev_level_q, prev_level_n;
	logic [31:0] last_edge_q, last_edge_n;
	logic [7:0]  bits_q, bits_n;
	logic [1:0]  gap_count_q, gap_count_n;

	// result register
	logic        out_valid_q;
	status_t     status_s2;
	logic        bit_valid_s2, bit_value_s2, frame_ready_s2, decode_error_s2;
	logic [6:0]  bit_index_s2;
	logic [7:0]  bit_count_s2;

	logic        adv;
	logic [31:0] elapsed;
	logic        hit_hs, hit_hm, hit_bs, hit_zero, hit_one, hit_gap;
	logic        bv, bval;
	logic [6:0]  bidx;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign elapsed  = now_s1 - last_edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q    <= RST_TOLERANCE;
			header_space_q <= RST_HEADER_SPACE;
			header_mark_q  <= RST_HEADER_MARK;
			bit_space_q    <= RST_BIT_SPACE;
			zero_mark_q    <= RST_ZERO_MARK;
			one_mark_q     <= RST_ONE_MARK;
			gap_q          <= RST_GAP;
			end_timeout_q  <= RST_END_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOLERANCE:    tolerance_q    <= cfg_data[15:0];
				CFG_HEADER_SPACE: header_space_q <= cfg_data[15:0];
				CFG_HEADER_MARK:  header_mark_q  <= cfg_data[15:0];
				CFG_BIT_SPACE:    bit_space_q    <= cfg_data[15:0];
				CFG_ZERO_MARK:    zero_mark_q    <= cfg_data[15:0];
				CFG_ONE_MARK:     one_mark_q     <= cfg_data[15:0];
				CFG_GAP:          gap_q          <= cfg_data[15:0];
				CFG_END_TIMEOUT:  end_timeout_q  <= cfg_data;
			endcase
		end
	end

	ipd_window u_win_hs (.nominal(header_space_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_hs));
	ipd_window u_win_hm (.nominal(header_mark_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_hm));
	ipd_window u_win_bs (.nominal(bit_space_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_bs));
	ipd_window u_win_zero (.nominal(zero_mark_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_zero));
	ipd_window u_win_one (.nominal(one_mark_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_one));
	ipd_window u_win_gap (.nominal(gap_q), .tolerance(tolerance_q),
		.elapsed(elapsed), .hit(hit_gap));

	always_comb begin
		status_n     = status_q;
		phase_n      = phase_q;
		prev_level_n = prev_level_q;
		last_edge_n  = last_edge_q;
		bits_n       = bits_q;
		gap_count_n  = gap_count_q;
		bv           = 1'b0;
		bval         = 1'b0;
		bidx         = 7'd0;

		if (operation_s1) begin
			status_n     = ST_IDLE;
			phase_n      = PH_HDR_SPACE;
			prev_level_n = 1'b1;
			last_edge_n  = 32'd0;
			bits_n       = 8'd0;
			gap_count_n  = 2'd0;
		end else if (status_q == ST_IDLE) begin
			if (!level_s1) begin
				status_n     = ST_RUN;
				last_edge_n  = now_s1;
				prev_level_n = 1'b0;
			end
		end else if (status_q == ST_RUN) begin
			prev_level_n = level_s1;
			if (bits_q >= FRAME_LIMIT) begin
				status_n = ST_OVERFLOW;
			end else if (elapsed > end_timeout_q) begin
				status_n = ST_TIMEOUT;
			end else if (prev_level_q != level_s1) begin
				last_edge_n = now_s1;
				unique case (phase_q)
					PH_HDR_SPACE: phase_n = hit_hs ? PH_HDR_MARK : PH_ERROR;
					PH_HDR_MARK:  phase_n = hit_hm ? PH_BIT_SPACE : PH_ERROR;
					PH_BIT_SPACE: phase_n = hit_bs ? PH_BIT_MARK : PH_ERROR;
					PH_BIT_MARK: begin
						if (hit_zero || hit_one) begin
							bv      = 1'b1;
							bval    = !hit_zero;
							bidx    = bits_q[6:0];
							bits_n  = bits_q + 8'd1;
							phase_n = PH_BIT_SPACE;
						end else if (hit_gap) begin
							phase_n = PH_AFTER_GAP;
							if (gap_count_q != 2'(GAP_COUNT_MAX)) begin
								gap_count_n = gap_count_q + 2'd1;
							end
						end else begin
							phase_n = PH_ERROR;
						end
					end
					PH_AFTER_GAP: begin
						// Only the first gap leads back into a header.
						if (gap_count_q == 2'd1) begin
							phase_n = hit_hs ? PH_HDR_MARK : PH_ERROR;
						end
					end
					default: phase_n = phase_q;
				endcase
				if (phase_n == PH_ERROR) begin
					status_n = ST_STOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			operation_s1 <= operation;
			level_s1     <= line_level;
			now_s1       <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= ST_IDLE;
			phase_q      <= PH_HDR_SPACE;
			prev_level_q <= 1'b1;
			last_edge_q  <= 32'd0;
			bits_q       <= 8'd0;
			gap_count_q  <= 2'd0;
		end else if (adv) begin
			status_q     <= status_n;
			phase_q      <= phase_n;
			prev_level_q <= prev_level_n;
			last_edge_q  <= last_edge_n;
			bits_q       <= bits_n;
			gap_count_q  <= gap_count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2       <= status_n;
			bit_valid_s2    <= bv;
			bit_value_s2    <= bval;
			bit_index_s2    <= bidx;
			bit_count_s2    <= bits_n;
			frame_ready_s2  <= ((status_n == ST_TIMEOUT) || (status_n == ST_OVERFLOW))
				&& (bits_n == FRAME_LIMIT);
			decode_error_s2 <= (phase_n == PH_ERROR) || (status_n == ST_STOP);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_s2;
	assign bit_valid    = bit_valid_s2;
	assign bit_value    = bit_value_s2;
	assign bit_index    = bit_index_s2;
	assign bit_count    = bit_count_s2;
	assign frame_ready  = frame_ready_s2;
	assign decode_error = decode_error_s2;

endmodule

### rtl/ipd_checker.sv
// Port-level checks for the pulse-distance IR decoder, and the bind that attaches them.
// Depends on ipd_pkg; sees only the ports of ir_pulse_distance_decoder.
module ipd_checker
	import ipd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        bit_valid,
	input logic        bit_value,
	input logic [6:0]  bit_index,
	input logic [7:0]  bit_count,
	input logic        frame_ready,
	input logic        decode_error
);

	// A stalled result word must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(bit_count)
			&& $stable(bit_valid) && $stable(bit_index))
		else $error("result word changed while stalled");

	// Bits are only decoded while the frame is running.
	a_bit_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_valid |-> status == ST_RUN)
		else $error("bit decoded outside a running frame");

	// A word without a bit carries zero bit fields.
	a_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bit_valid |-> bit_value == 1'b0 && bit_index == 7'd0)
		else $error("bit fields set without a decoded bit");

	// A ready frame has ended by timeout or overflow.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ready |-> status == ST_TIMEOUT || status == ST_OVERFLOW)
		else $error("frame ready while frame not ended");

	// An interval error always leaves the decoder stopped.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decode_error |-> status == ST_STOP)
		else $error("decode error without stopped status");

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.bit_valid    (bit_valid),
	.bit_value    (bit_value),
	.bit_index    (bit_index),
	.bit_count    (bit_count),
	.frame_ready  (frame_ready),
	.decode_error (decode_error)
);
